[hw/rtl/fifo_with_max_priority_extract_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the priority-extract queue
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_MAX_PRIORITY_EXTRACT_MACROS_SVH
`define FIFO_WITH_MAX_PRIORITY_EXTRACT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked assertion, switched off while reset is held.
`define FMPE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define FMPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FMPE_ASSERT(lbl, clk, rst_n, prop, msg)
`define FMPE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hw/rtl/fmpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpe_pkg
// Shared codes and types for the priority-extract queue.
// ----------------------------------------------------------------------------
package fmpe_pkg;

	// Command codes.
	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_POP     = 2'd1;
	localparam logic [1:0] CMD_EXTRACT = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int ID_W    = 16;
	localparam int PRI_W   = 8;
	localparam int ENTRY_W = ID_W + PRI_W;
	localparam int COUNT_W = 5;

	// One stored slot: identifier above priority.
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
	} entry_t;

	// Command word handed to the engine.
	typedef struct packed {
		logic [1:0]       command;
		logic [ID_W-1:0]  entry_id;
		logic [PRI_W-1:0] priority_req;
	} req_t;

	// Result word produced by the engine.
	typedef struct packed {
		logic [1:0]         status;
		logic [ID_W-1:0]    out_id;
		logic [PRI_W-1:0]   out_priority;
		logic [COUNT_W-1:0] count;
	} res_t;

	// Engine status towards the top level.
	typedef struct packed {
		logic idle;
		logic done;
	} eng_stat_t;

endpackage

[hw/rtl/fmpe_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpe_in_if
// Command channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface fmpe_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] entry_id;
	logic [7:0]  priority_req;

	modport source (output valid, output command, output entry_id,
		output priority_req, input ready);
	modport sink (input valid, input command, input entry_id,
		input priority_req, output ready);
endinterface

[hw/rtl/fmpe_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpe_out_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface fmpe_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] out_id;
	logic [7:0]  out_priority;
	logic [4:0]  count;

	modport source (output valid, output status, output out_id,
		output out_priority, output count, input ready);
	modport sink (input valid, input status, input out_id,
		input out_priority, input count, output ready);
endinterface

[hw/rtl/fmpe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fmpe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/fmpe_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmpe_engine
// Slot store and sequencer: scans the slots with one comparator and closes
// the gap left by a removed entry one slot per cycle.
// ----------------------------------------------------------------------------
module fmpe_engine #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  fmpe_pkg::req_t      req,
	input  logic                ack,
	output fmpe_pkg::eng_stat_t stat,
	output fmpe_pkg::res_t      res
);

	localparam int AW = $clog2(DEPTH);
	localparam int OW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [OW-1:0]           occ_q;
	logic [OW-1:0]           cmp_idx_q;
	logic [OW-1:0]           limit_q;
	logic [OW-1:0]           sh_idx_q;
	logic [AW-1:0]           best_q;
	fmpe_pkg::entry_t        best_ent_q;
	fmpe_pkg::res_t          res_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [AW-1:0]           ram_raddr;
	logic [fmpe_pkg::ENTRY_W-1:0] ram_wdata;
	logic [fmpe_pkg::ENTRY_W-1:0] ram_rdata;
	fmpe_pkg::entry_t        rd_ent;

	logic                    take;
	logic                    last_cmp;
	logic [AW-1:0]           nxt_best;
	fmpe_pkg::entry_t        nxt_ent;
	logic [OW-1:0]           nxt_sh;
	logic [OW-1:0]           cmp_nxt;
	logic [OW-1:0]           sh_nxt;
	logic                    full;

	// Occupancy to the five-bit count field, keeping the low bits.
	function automatic logic [fmpe_pkg::COUNT_W-1:0] to_count(input logic [OW-1:0] v);
		logic [OW+fmpe_pkg::COUNT_W-1:0] w;
		w = {{fmpe_pkg::COUNT_W{1'b0}}, v};
		return w[fmpe_pkg::COUNT_W-1:0];
	endfunction

	// Builds a whole result word from a status, the removed entry and the
	// occupancy left behind.
	function automatic fmpe_pkg::res_t make_res(input logic [1:0] st,
			input fmpe_pkg::entry_t ent, input logic [OW-1:0] occ);
		fmpe_pkg::res_t r;
		r.status       = st;
		r.out_id       = ent.id;
		r.out_priority = ent.pri;
		r.count        = to_count(occ);
		return r;
	endfunction

	fmpe_ram #(
		.WIDTH (fmpe_pkg::ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_ent = fmpe_pkg::entry_t'(ram_rdata);

	// Shared comparator: the slot just read against the best so far.
	// A strictly larger priority is needed, so the entry nearest the head wins ties.
	assign take     = (cmp_idx_q == '0) || (rd_ent.pri > best_ent_q.pri);
	assign nxt_best = take ? cmp_idx_q[AW-1:0] : best_q;
	assign nxt_ent  = take ? rd_ent : best_ent_q;
	assign last_cmp = (cmp_idx_q == limit_q - OW'(1));
	assign nxt_sh   = OW'(nxt_best) + OW'(1);
	assign cmp_nxt  = cmp_idx_q + OW'(1);
	assign sh_nxt   = sh_idx_q + OW'(1);
	assign full     = (occ_q == OW'(DEPTH));

	// Memory port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (start && req.command == fmpe_pkg::CMD_PUSH && !full) begin
					ram_we    = 1'b1;
					ram_waddr = occ_q[AW-1:0];
					ram_wdata = {req.entry_id, req.priority_req};
				end
			end
			S_SCAN: begin
				if (!last_cmp) begin
					ram_raddr = cmp_nxt[AW-1:0];
				end else if (nxt_sh < occ_q) begin
					ram_raddr = nxt_sh[AW-1:0];
				end
			end
			S_SHIFT: begin
				// Slot sh_idx moves down by one while the next one is fetched.
				ram_we    = 1'b1;
				ram_waddr = sh_idx_q[AW-1:0] - AW'(1);
				ram_wdata = ram_rdata;
				if (sh_nxt < occ_q) begin
					ram_raddr = sh_nxt[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			occ_q      <= '0;
			cmp_idx_q  <= '0;
			limit_q    <= '0;
			sh_idx_q   <= '0;
			best_q     <= '0;
			best_ent_q <= '0;
			res_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (req.command)
							fmpe_pkg::CMD_PUSH: begin
								if (full) begin
									res_q <= make_res(fmpe_pkg::ST_FULL, '0, occ_q);
								end else begin
									occ_q <= occ_q + OW'(1);
									res_q <= make_res(fmpe_pkg::ST_OK, '0,
										occ_q + OW'(1));
								end
								state_q <= S_DONE;
							end
							fmpe_pkg::CMD_POP, fmpe_pkg::CMD_EXTRACT: begin
								if (occ_q == '0) begin
									res_q   <= make_res(fmpe_pkg::ST_EMPTY, '0, '0);
									state_q <= S_DONE;
								end else begin
									// Slot zero is being read this cycle.
									cmp_idx_q <= '0;
									limit_q   <= (req.command == fmpe_pkg::CMD_POP) ?
										OW'(1) : occ_q;
									state_q   <= S_SCAN;
								end
							end
							default: begin
								res_q   <= make_res(fmpe_pkg::ST_OK, '0, occ_q);
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					best_q     <= nxt_best;
					best_ent_q <= nxt_ent;
					cmp_idx_q  <= cmp_nxt;
					if (last_cmp) begin
						if (nxt_sh < occ_q) begin
							sh_idx_q <= nxt_sh;
							state_q  <= S_SHIFT;
						end else begin
							// Removed entry was the tail: nothing to close up.
							occ_q   <= occ_q - OW'(1);
							res_q   <= make_res(fmpe_pkg::ST_OK, nxt_ent,
								occ_q - OW'(1));
							state_q <= S_DONE;
						end
					end
				end
				S_SHIFT: begin
					if (sh_nxt < occ_q) begin
						sh_idx_q <= sh_nxt;
					end else begin
						occ_q   <= occ_q - OW'(1);
						res_q   <= make_res(fmpe_pkg::ST_OK, best_ent_q,
							occ_q - OW'(1));
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign res       = res_q;

endmodule

[hw/rtl/fifo_with_max_priority_extract.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_max_priority_extract
// Ordered queue of identifier/priority entries with push, pop and
// highest-priority extract.
// ----------------------------------------------------------------------------
// Usage:
//   Command words arrive on req (valid/ready): push appends at the tail, pop
//   removes the head, extract removes the entry with the largest priority,
//   the one nearest the head on a tie. Every command word yields exactly one
//   result word on rsp: status, removed entry and the count held afterwards.
//   A push, an empty removal, a full push or an unused code goes straight
//   to a finished result; pop scans the head slot and extract every slot,
//   then the entries behind the removed one move down to close the gap.
//   Removals are paced by the single read port of the slot memory: one slot
//   a cycle is scanned past one comparator, and closing the gap moves one
//   slot a cycle. A new word is accepted only once the last result is
//   registered on rsp.
//   req.ready is high only while the engine is idle. A finished result sits
//   in the output register, so a new command may be accepted while rsp is
//   stalled; that command completes but waits in the engine until it frees.
//   Reset empties the queue at once; the slot memory itself is not cleared.
// ----------------------------------------------------------------------------
`include "fifo_with_max_priority_extract_macros.svh"

module fifo_with_max_priority_extract #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	fmpe_in_if.sink           req,
	fmpe_out_if.source        rsp
);

	fmpe_pkg::req_t      eng_req;
	fmpe_pkg::res_t      eng_res;
	fmpe_pkg::eng_stat_t eng_stat;
	logic                start;
	logic                ack;

	logic                out_vld_q;
	fmpe_pkg::res_t      out_res_q;

	// Command side.
	assign req.ready = eng_stat.idle;
	assign start     = req.valid && req.ready;
	assign eng_req   = '{command: req.command, entry_id: req.entry_id,
		priority_req: req.priority_req};

	fmpe_engine #(
		.DEPTH (DEPTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (eng_req),
		.ack    (ack),
		.stat   (eng_stat),
		.res    (eng_res)
	);

	// Output register: takes a finished word whenever it is free or draining.
	assign ack = eng_stat.done && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_res_q <= '0;
		end else begin
			if (ack) begin
				out_vld_q <= 1'b1;
				out_res_q <= eng_res;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.status       = out_res_q.status;
	assign rsp.out_id       = out_res_q.out_id;
	assign rsp.out_priority = out_res_q.out_priority;
	assign rsp.count        = out_res_q.count;

	// An accepted command always takes the engine out of idle.
	`FMPE_ASSERT(a_start_busy, clk, arst_n, start |=> !eng_stat.idle, "engine stayed idle after a command")
	// The engine is never idle and done at once.
	`FMPE_ASSERT_ALWAYS(a_stat_excl, clk, !(eng_stat.idle && eng_stat.done), "engine idle and done together")
	// A removal from an empty queue leaves nothing held and returns no entry.
	`FMPE_ASSERT(a_empty_res, clk, arst_n, (rsp.valid && rsp.status == fmpe_pkg::ST_EMPTY) |-> (rsp.count == '0 && rsp.out_id == '0 && rsp.out_priority == '0), "empty status with data")
	// A full push reports a full queue.
	`FMPE_ASSERT(a_full_cnt, clk, arst_n, (rsp.valid && rsp.status == fmpe_pkg::ST_FULL) |-> (DEPTH > 31 || rsp.count == 5'(DEPTH)), "full status with short count")

endmodule
